// File: rtl/lseg_pkg.sv
package lseg_pkg;

   // Effect selector codes carried on the request word.
   localparam logic MODE_RAINBOW = 1'b0;
   localparam logic MODE_BREATH  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_HUE_STEP      = 2'd0,
      CSR_HUE_SPACING   = 2'd1,
      CSR_RAINBOW_LEVEL = 2'd2,
      CSR_BREATH_STEP   = 2'd3
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam int HUE_STEP_RESET      = 3;
   localparam int HUE_SPACING_RESET   = 45;
   localparam int RAINBOW_LEVEL_RESET = 51;
   localparam int BREATH_STEP_RESET   = 1043;

   // Effect constants.
   localparam int HUE_WRAP   = 360;
   localparam int FADE_STEPS = 10;
   localparam int FULL_LEVEL = 255;
   localparam int SINE_MID   = 153;
   localparam int SINE_SCALE = 1632;

   // Reciprocals for the constant divisions: n / 10 and m / 600.
   localparam int RECIP_10  = 6554;
   localparam int SHIFT_10  = 16;
   localparam int RECIP_600 = 223697;
   localparam int SHIFT_600 = 27;

   // Default parameter values.
   localparam int LED_COUNT_DEFAULT        = 8;
   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Quotient width of the sine divider; the quotient never exceeds 102.
   localparam int DIV_Q_W = 7;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] op_a;
      logic [MUL_B_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quo;
      logic               rem_nz;
   } div_stat_type;

endpackage

// File: rtl/lseg_mul.sv
module lseg_mul
   import lseg_pkg::*;
(
   input  logic               clock,
   input  mul_req_type        mul_req,
   output logic [MUL_P_W-1:0] prod_ff
);

   logic [MUL_P_W-1:0] prod_in;

   // One product per cycle; the result is held while the unit is not issued.
   always_comb begin
      prod_in = prod_ff;
      if (mul_req.en) begin
         prod_in = MUL_P_W'(mul_req.op_a) * MUL_P_W'(mul_req.op_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/lseg_div.sv
module lseg_div
   import lseg_pkg::*;
#(
   parameter int NUM_W = 29,
   parameter int DEN_W = 23
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_stat_type     div_stat
);

   localparam int STEP_W = $clog2(DIV_Q_W);

   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   trial_ff, trial_in;
   logic [DIV_Q_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               fits;

   // Restoring division, one quotient bit per cycle from the top bit down.
   always_comb begin
      rem_in   = rem_ff;
      trial_in = trial_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      fits     = (rem_ff >= trial_ff);
      if (start) begin
         rem_in   = num;
         trial_in = NUM_W'(den) << (DIV_Q_W - 1);
         quo_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial_ff;
         end
         quo_in   = {quo_ff[DIV_Q_W-2:0], fits};
         trial_in = trial_ff >> 1;
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      trial_ff <= trial_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_stat.done   = done_ff;
   assign div_stat.quo    = quo_ff;
   assign div_stat.rem_nz = (rem_ff != '0);

endmodule

// File: rtl/led_strip_effect_generator_top.sv
// LED strip effect generator.
// Each word on the req_ channel is one frame tick; req_tdata[0] asks for the
// rainbow (0) or the red breathing effect (1). For every tick the block sends
// LED_COUNT words on the rsp_ channel, LED 0 first, with rsp_tlast on the last.
// A change of effect first plays eleven fade frames of the old effect.
// The csr_ channel writes the four effect registers; write it only between
// frames, after the last word of a frame has been taken.
// Sequencing: one shared multiplier and a bit-serial divider do all the math
// under a small sequencer. A frame steps through S_LVL, S_CMUL and S_C; in
// plain breathing, S_IDX, S_Q, S_NUM, S_DIV and S_DWAIT follow, where the sine
// entry is computed with a seven-step division. Each LED then passes S_KMUL,
// S_XMUL and S_LOAD: two chained multiplies on the shared unit, then the load
// into the output register. req_tready is high only between frames. rsp_ has
// one output register: while the receiver stalls, the next LED waits fully
// computed and the sequencer holds.
// Reset is synchronous and returns the configuration registers, control state
// and effect state to their defaults; the block is ready on the first cycle after reset.
module led_strip_effect_generator_top
   import lseg_pkg::*;
#(
   parameter int LED_COUNT        = LED_COUNT_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] requested_mode, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] led_index, [10:3] red, [18:11] green, [26:19] blue, [31:27] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,   // last_led
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int J_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int A_W   = J_W + 1;
   localparam int Q_W   = 2 * A_W - 3;
   localparam int DEN_W = 2 * A_W + 1;
   localparam int NUM_W = 2 * A_W + 7;
   localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int DEN5  = 5 * SINE_TABLE_DEPTH * SINE_TABLE_DEPTH;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_LVL   = 12'b0000_0000_0010,
      S_CMUL  = 12'b0000_0000_0100,
      S_C     = 12'b0000_0000_1000,
      S_IDX   = 12'b0000_0001_0000,
      S_Q     = 12'b0000_0010_0000,
      S_NUM   = 12'b0000_0100_0000,
      S_DIV   = 12'b0000_1000_0000,
      S_DWAIT = 12'b0001_0000_0000,
      S_KMUL  = 12'b0010_0000_0000,
      S_XMUL  = 12'b0100_0000_0000,
      S_LOAD  = 12'b1000_0000_0000
   } state_type;

   // Control state.
   state_type      state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [8:0]     hue_step_ff, hue_step_in;
   logic [8:0]     hue_spacing_ff, hue_spacing_in;
   logic [7:0]     rainbow_level_ff, rainbow_level_in;
   logic [15:0]    breath_step_ff, breath_step_in;
   logic           active_ff, active_in;
   logic [8:0]     hue_pos_ff, hue_pos_in;
   logic [15:0]    acc_ff, acc_in;
   logic           fading_ff, fading_in;
   logic [3:0]     fade_count_ff, fade_count_in;
   logic           frame_fade_ff, frame_fade_in;
   logic [LED_W-1:0] led_ff, led_in;

   // Per-frame and per-LED working values.
   logic           req_ff, req_in;
   logic [3:0]     t_ff, t_in;
   logic [11:0]    n_ff, n_in;
   logic [7:0]     c_ff, c_in;
   logic [A_W-1:0] a_ff, a_in;
   logic           upper_ff, upper_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [7:0]     sine_red_ff, sine_red_in;
   logic [8:0]     h_ff, h_in;
   logic [2:0]     rsp_led_ff, rsp_led_in;
   logic [7:0]     rsp_red_ff, rsp_red_in;
   logic [7:0]     rsp_green_ff, rsp_green_in;
   logic [7:0]     rsp_blue_ff, rsp_blue_in;
   logic           rsp_last_ff, rsp_last_in;

   // Shared units.
   mul_req_type        mul_req;
   logic [MUL_P_W-1:0] prod_ff;
   logic               div_start;
   div_stat_type       div_stat;

   // Combinational helpers.
   logic [8:0]     spacing_mod, step_mod;
   logic [9:0]     h_sum, pos_sum;
   logic [6:0]     rem120;
   logic [5:0]     k_val;
   logic [7:0]     x_val;
   logic [J_W-1:0] j_val;
   logic [A_W-1:0] a2_val;
   logic [Q_W-1:0] q_val;
   logic           start_fade;
   logic [3:0]     fc_eff;
   logic           is_last;
   logic           can_load;
   logic [7:0]     col_r, col_g, col_b;

   lseg_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   lseg_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (prod_ff[NUM_W-1:0]),
      .den      (den_ff),
      .div_stat (div_stat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_blue_ff, rsp_green_ff, rsp_red_ff, rsp_led_ff};

   // Register values reduced modulo 360.
   assign spacing_mod = (hue_spacing_ff >= 9'(HUE_WRAP)) ? hue_spacing_ff - 9'(HUE_WRAP)
                                                         : hue_spacing_ff;
   assign step_mod    = (hue_step_ff >= 9'(HUE_WRAP)) ? hue_step_ff - 9'(HUE_WRAP)
                                                      : hue_step_ff;
   assign h_sum   = {1'b0, h_ff} + {1'b0, spacing_mod};
   assign pos_sum = {1'b0, hue_pos_ff} + {1'b0, step_mod};

   // Hue ramp: k = 60 - |(h mod 120) - 60|.
   always_comb begin
      if (h_ff < 9'd120) begin
         rem120 = 7'(h_ff);
      end else if (h_ff < 9'd240) begin
         rem120 = 7'(h_ff - 9'd120);
      end else begin
         rem120 = 7'(h_ff - 9'd240);
      end
      k_val = (rem120 >= 7'd60) ? 6'(7'd120 - rem120) : 6'(rem120);
   end

   assign x_val = prod_ff[SHIFT_600 +: 8];

   // Sine table address folded into the half-turn.
   assign j_val  = prod_ff[16 +: J_W];
   assign a2_val = {j_val, 1'b0};
   assign q_val  = prod_ff[Q_W-1:0];

   assign start_fade = !fading_ff && (req_tdata[0] != active_ff);
   assign fc_eff     = start_fade ? 4'(FADE_STEPS) : fade_count_ff;
   assign is_last    = (led_ff == LED_W'(LED_COUNT - 1));
   assign can_load   = !rsp_valid_ff || rsp_tready;

   // Color of the current LED.
   always_comb begin
      col_r = '0;
      col_g = '0;
      col_b = '0;
      if (active_ff == MODE_BREATH) begin
         col_r = frame_fade_ff ? c_ff : sine_red_ff;
      end else if (h_ff < 9'd60) begin
         col_r = c_ff;
         col_g = x_val;
      end else if (h_ff < 9'd120) begin
         col_r = x_val;
         col_g = c_ff;
      end else if (h_ff < 9'd180) begin
         col_g = c_ff;
         col_b = x_val;
      end else if (h_ff < 9'd240) begin
         col_g = x_val;
         col_b = c_ff;
      end else if (h_ff < 9'd300) begin
         col_r = x_val;
         col_b = c_ff;
      end else begin
         col_r = c_ff;
         col_b = x_val;
      end
   end

   // Configuration writes.
   always_comb begin
      hue_step_in      = hue_step_ff;
      hue_spacing_in   = hue_spacing_ff;
      rainbow_level_in = rainbow_level_ff;
      breath_step_in   = breath_step_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_HUE_STEP:      hue_step_in      = csr_data[8:0];
            CSR_HUE_SPACING:   hue_spacing_in   = csr_data[8:0];
            CSR_RAINBOW_LEVEL: rainbow_level_in = csr_data[7:0];
            CSR_BREATH_STEP:   breath_step_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Frame sequencer.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      active_in     = active_ff;
      hue_pos_in    = hue_pos_ff;
      acc_in        = acc_ff;
      fading_in     = fading_ff;
      fade_count_in = fade_count_ff;
      frame_fade_in = frame_fade_ff;
      led_in        = led_ff;
      req_in        = req_ff;
      t_in          = t_ff;
      n_in          = n_ff;
      c_in          = c_ff;
      a_in          = a_ff;
      upper_in      = upper_ff;
      den_in        = den_ff;
      sine_red_in   = sine_red_ff;
      h_in          = h_ff;
      rsp_led_in    = rsp_led_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_last_in   = rsp_last_ff;
      mul_req       = '0;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in        = req_tdata[0];
               frame_fade_in = fading_ff || start_fade;
               t_in          = (fading_ff || start_fade)
                               ? ((fc_eff > 4'(FADE_STEPS)) ? 4'(FADE_STEPS) : fc_eff)
                               : 4'(FADE_STEPS);
               if (start_fade) begin
                  fading_in     = 1'b1;
                  fade_count_in = 4'(FADE_STEPS);
               end
               h_in     = hue_pos_ff;
               led_in   = '0;
               state_in = S_LVL;
            end
         end
         // Brightness times fade step.
         S_LVL: begin
            mul_req.en   = 1'b1;
            mul_req.op_a = (active_ff == MODE_RAINBOW) ? MUL_A_W'(rainbow_level_ff)
                                                       : MUL_A_W'(FULL_LEVEL);
            mul_req.op_b = MUL_B_W'(t_ff);
            state_in     = S_CMUL;
         end
         // Full channel level: n / 10.
         S_CMUL: begin
            n_in         = prod_ff[11:0];
            mul_req.en   = 1'b1;
            mul_req.op_a = MUL_A_W'(prod_ff[11:0]);
            mul_req.op_b = MUL_B_W'(RECIP_10);
            state_in     = S_C;
         end
         S_C: begin
            c_in = prod_ff[SHIFT_10 +: 8];
            if (active_ff == MODE_BREATH && !frame_fade_ff) begin
               mul_req.en   = 1'b1;
               mul_req.op_a = MUL_A_W'(acc_ff);
               mul_req.op_b = MUL_B_W'(SINE_TABLE_DEPTH);
               state_in     = S_IDX;
            end else begin
               state_in = S_KMUL;
            end
         end
         // Sine entry: fold the table index into a half turn.
         S_IDX: begin
            if (a2_val >= A_W'(SINE_TABLE_DEPTH)) begin
               a_in     = a2_val - A_W'(SINE_TABLE_DEPTH);
               upper_in = 1'b1;
            end else begin
               a_in     = a2_val;
               upper_in = 1'b0;
            end
            state_in = S_Q;
         end
         S_Q: begin
            mul_req.en   = 1'b1;
            mul_req.op_a = MUL_A_W'(a_ff);
            mul_req.op_b = MUL_B_W'(A_W'(SINE_TABLE_DEPTH) - a_ff);
            state_in     = S_NUM;
         end
         S_NUM: begin
            den_in       = DEN_W'(DEN5) - DEN_W'({q_val, 2'b00});
            mul_req.en   = 1'b1;
            mul_req.op_a = MUL_A_W'(q_val);
            mul_req.op_b = MUL_B_W'(SINE_SCALE);
            state_in     = S_DIV;
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         // Floor in the rising half, ceiling in the falling half.
         S_DWAIT: begin
            if (div_stat.done) begin
               if (upper_ff) begin
                  sine_red_in = 8'(SINE_MID) - (8'(div_stat.quo) + 8'(div_stat.rem_nz));
               end else begin
                  sine_red_in = 8'(SINE_MID) + 8'(div_stat.quo);
               end
               state_in = S_KMUL;
            end
         end
         // Secondary channel: n * k / 600.
         S_KMUL: begin
            mul_req.en   = 1'b1;
            mul_req.op_a = MUL_A_W'(n_ff);
            mul_req.op_b = MUL_B_W'(k_val);
            state_in     = S_XMUL;
         end
         S_XMUL: begin
            mul_req.en   = 1'b1;
            mul_req.op_a = MUL_A_W'(prod_ff[17:0]);
            mul_req.op_b = MUL_B_W'(RECIP_600);
            state_in     = S_LOAD;
         end
         // Hand the LED to the output register and step to the next one.
         S_LOAD: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_led_in   = 3'(led_ff);
               rsp_red_in   = col_r;
               rsp_green_in = col_g;
               rsp_blue_in  = col_b;
               rsp_last_in  = is_last;
               if (is_last) begin
                  if (frame_fade_ff) begin
                     if (t_ff == 4'd0) begin
                        fading_in     = 1'b0;
                        active_in     = req_ff;
                        fade_count_in = 4'(FADE_STEPS);
                     end else begin
                        fade_count_in = t_ff - 4'd1;
                     end
                  end else if (active_ff == MODE_RAINBOW) begin
                     hue_pos_in = (pos_sum >= 10'(HUE_WRAP)) ? 9'(pos_sum - 10'(HUE_WRAP))
                                                            : 9'(pos_sum);
                  end else begin
                     acc_in = acc_ff + breath_step_ff;
                  end
                  state_in = S_IDLE;
               end else begin
                  led_in   = led_ff + LED_W'(1);
                  h_in     = (h_sum >= 10'(HUE_WRAP)) ? 9'(h_sum - 10'(HUE_WRAP)) : 9'(h_sum);
                  state_in = S_KMUL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      t_ff         <= t_in;
      n_ff         <= n_in;
      c_ff         <= c_in;
      a_ff         <= a_in;
      upper_ff     <= upper_in;
      den_ff       <= den_in;
      sine_red_ff  <= sine_red_in;
      h_ff         <= h_in;
      rsp_led_ff   <= rsp_led_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         hue_step_ff      <= 9'(HUE_STEP_RESET);
         hue_spacing_ff   <= 9'(HUE_SPACING_RESET);
         rainbow_level_ff <= 8'(RAINBOW_LEVEL_RESET);
         breath_step_ff   <= 16'(BREATH_STEP_RESET);
         active_ff        <= MODE_RAINBOW;
         hue_pos_ff       <= '0;
         acc_ff           <= '0;
         fading_ff        <= 1'b0;
         fade_count_ff    <= 4'(FADE_STEPS);
         frame_fade_ff    <= 1'b0;
         led_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         hue_step_ff      <= hue_step_in;
         hue_spacing_ff   <= hue_spacing_in;
         rainbow_level_ff <= rainbow_level_in;
         breath_step_ff   <= breath_step_in;
         active_ff        <= active_in;
         hue_pos_ff       <= hue_pos_in;
         acc_ff           <= acc_in;
         fading_ff        <= fading_in;
         fade_count_ff    <= fade_count_in;
         frame_fade_ff    <= frame_fade_in;
         led_ff           <= led_in;
      end
   end

   // The fade counter stays within one fade sequence.
   assert property (@(posedge clock) disable iff (reset)
      fade_count_ff <= 4'(FADE_STEPS))
      else $error("fade counter out of range");

   // Outside a fade the counter rests at its full value.
   assert property (@(posedge clock) disable iff (reset)
      !fading_ff |-> fade_count_ff == 4'(FADE_STEPS))
      else $error("fade counter not reloaded after fade");

   // The hue position always stays below a full turn.
   assert property (@(posedge clock) disable iff (reset)
      hue_pos_ff < 9'(HUE_WRAP))
      else $error("hue position beyond a full turn");

   // A taken tick blocks further ticks until its frame is done.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("tick accepted while a frame is running");

endmodule
